FILE: rtl/core/ctse_pkg.sv
package ctse_pkg;

  // Reset values of the configuration registers
  localparam logic [15:0] LONG_PRESS_RESET   = 16'd350;
  localparam logic [15:0] BLINK_PERIOD_RESET = 16'd1000;

  // Configuration register indexes
  localparam logic CFG_LONG_PRESS   = 1'b0;
  localparam logic CFG_BLINK_PERIOD = 1'b1;

  // Request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  // Key codes; the unused code behaves as no key
  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_A    = 2'd1;
  localparam logic [1:0] KEY_B    = 2'd2;

  // Field selection codes
  localparam logic [1:0] SEL_SECONDS = 2'd1;
  localparam logic [1:0] SEL_MINUTES = 2'd2;
  localparam logic [1:0] SEL_HOURS   = 2'd3;

  // Session outcome codes
  localparam logic [1:0] OUT_EDITING   = 2'd0;
  localparam logic [1:0] OUT_SAVED     = 2'd1;
  localparam logic [1:0] OUT_CANCELLED = 2'd2;

  // Wrap limits and counter ceiling
  localparam logic [5:0]  SEC_MIN_LAST = 6'd59;
  localparam logic [4:0]  HOUR_LAST    = 5'd12;
  localparam logic [15:0] PRESS_MAX    = 16'hFFFF;

  // One input word, request kind included
  typedef struct packed {
    logic [5:0] load_seconds;
    logic [5:0] load_minutes;
    logic [4:0] load_hours;
    logic [1:0] key_code;
    logic       req_type;
  } ctse_item_t;

  // One result word, first field in the highest bits
  typedef struct packed {
    logic [7:0] bcd_seconds;
    logic [7:0] bcd_minutes;
    logic [5:0] bcd_hours;
    logic [1:0] outcome;
    logic [1:0] selected_field;
    logic [2:0] blank_mask;
    logic [5:0] shown_seconds;
    logic [5:0] shown_minutes;
    logic [4:0] shown_hours;
  } ctse_result_t;

  // Split a value below 64 into packed BCD: tens in [7:4], units in [3:0]
  function automatic logic [7:0] to_bcd(input logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] rest;
    tens = (v >= 6'd60) ? 3'd6 :
           (v >= 6'd50) ? 3'd5 :
           (v >= 6'd40) ? 3'd4 :
           (v >= 6'd30) ? 3'd3 :
           (v >= 6'd20) ? 3'd2 :
           (v >= 6'd10) ? 3'd1 : 3'd0;
    rest = v - 6'({3'd0, tens} * 6'd10);
    return {1'b0, tens, rest[3:0]};
  endfunction

endpackage

FILE: rtl/core/clock_time_setting_keypad_fsm_top.sv
// Pipeline: a word accepted into the input register has its result captured in the
// result register when that stage advances; a full result register holds it there.
// Throughput: one word per cycle; the input register and the result register each
// take a new word whenever the stage after them moves.
// Reset: synchronous, active low; clears the session state, restores the register
// defaults (long press 350 ticks, blink period 1000) and empties both stages.
module clock_time_setting_keypad_fsm_top
  import ctse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input word
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // key_code, load_hours, load_minutes, load_seconds
  input  logic        in_tuser,   // req_type
  // Result word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // shown_hours, shown_minutes, shown_seconds,
                                  // blank_mask, selected_field, outcome,
                                  // bcd_hours, bcd_minutes, bcd_seconds
  // Configuration writes
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0]  long_press_r;
  logic [15:0]  blink_period_r;
  logic         in_valid_r;
  ctse_item_t   in_item_r;
  logic         out_valid_r;
  ctse_result_t out_res_r;
  ctse_result_t step_res;
  logic         advance;
  logic         step_en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r   <= LONG_PRESS_RESET;
      blink_period_r <= BLINK_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LONG_PRESS:   long_press_r   <= cfg_wdata;
        CFG_BLINK_PERIOD: blink_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: each stage moves when the stage after it is free or draining
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign step_en   = in_valid_r && advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.req_type     <= in_tuser;
      in_item_r.key_code     <= in_tdata[1:0];
      in_item_r.load_hours   <= in_tdata[6:2];
      in_item_r.load_minutes <= in_tdata[12:7];
      in_item_r.load_seconds <= in_tdata[18:13];
    end
  end

  // Session logic
  ctse_editor u_editor (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (step_en),
    .item             (in_item_r),
    .long_press_ticks (long_press_r),
    .blink_period     (blink_period_r),
    .result           (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

`ifndef ASSERT_OFF
  // The BCD time appears only with a save
  a_bcd_only_on_save: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.outcome != OUT_SAVED)) |->
      ((out_res_r.bcd_hours == 6'd0) && (out_res_r.bcd_minutes == 8'd0) &&
       (out_res_r.bcd_seconds == 8'd0)))
    else $error("BCD time present without a save");

  // The selection always names one of the three fields
  a_select_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.selected_field != 2'd0))
    else $error("selection outside the three fields");

  // A held input word moves on only when the result register takes it
  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_item_r)))
    else $error("input word lost while the result register was full");

  // A word in the input register reaches the result register when it advances
  a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_valid_r)
    else $error("processed word did not reach the result register");

  // Both stages are empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !in_valid_r))
    else $error("stages not empty after reset");
`endif

endmodule

FILE: rtl/core/ctse_editor.sv
module ctse_editor
  import ctse_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  ctse_item_t    item,
  input  logic [15:0]   long_press_ticks,
  input  logic [15:0]   blink_period,
  output ctse_result_t  result
);

  logic [4:0]  edit_hours_r,      edit_hours_nxt;
  logic [5:0]  edit_minutes_r,    edit_minutes_nxt;
  logic [5:0]  edit_seconds_r,    edit_seconds_nxt;
  logic [1:0]  field_select_r,    field_select_nxt;
  logic [15:0] press_count_r,     press_count_nxt;
  logic [1:0]  press_kind_r,      press_kind_nxt;
  logic [15:0] blink_count_r,     blink_count_nxt;
  logic [4:0]  latched_hours_r,   latched_hours_nxt;
  logic [5:0]  latched_minutes_r, latched_minutes_nxt;
  logic [5:0]  latched_seconds_r, latched_seconds_nxt;
  logic [2:0]  blanked_r,         blanked_nxt;
  logic [1:0]  outcome;

  logic [15:0] press_inc;
  logic        key_held;
  logic        long_hit;
  logic        short_ok;
  logic [15:0] half_period;
  logic [15:0] blink_dec;
  logic [7:0]  bcd_h;
  logic [7:0]  bcd_m;
  logic [7:0]  bcd_s;

  // Press counter step and the long and short press tests
  assign press_inc   = (press_count_r != PRESS_MAX) ? press_count_r + 16'd1 : press_count_r;
  assign key_held    = (item.key_code == KEY_A) || (item.key_code == KEY_B);
  assign long_hit    = press_inc > long_press_ticks;
  assign short_ok    = (press_count_r != 16'd0) && (press_count_r < long_press_ticks);
  assign half_period = {1'b0, blink_period[15:1]};
  assign blink_dec   = blink_count_r - 16'd1;

  // Next state for one word
  always_comb begin
    edit_hours_nxt      = edit_hours_r;
    edit_minutes_nxt    = edit_minutes_r;
    edit_seconds_nxt    = edit_seconds_r;
    field_select_nxt    = field_select_r;
    press_count_nxt     = press_count_r;
    press_kind_nxt      = press_kind_r;
    blink_count_nxt     = blink_count_r;
    latched_hours_nxt   = latched_hours_r;
    latched_minutes_nxt = latched_minutes_r;
    latched_seconds_nxt = latched_seconds_r;
    blanked_nxt         = blanked_r;
    outcome             = OUT_EDITING;

    if (item.req_type == REQ_LOAD) begin
      // A load opens a fresh session with the given time on display
      edit_hours_nxt      = item.load_hours;
      edit_minutes_nxt    = item.load_minutes;
      edit_seconds_nxt    = item.load_seconds;
      field_select_nxt    = SEL_SECONDS;
      press_count_nxt     = 16'd0;
      press_kind_nxt      = KEY_NONE;
      blink_count_nxt     = blink_period;
      latched_hours_nxt   = item.load_hours;
      latched_minutes_nxt = item.load_minutes;
      latched_seconds_nxt = item.load_seconds;
      blanked_nxt         = 3'd0;
    end else begin
      if (key_held) begin
        // A hold past the limit saves or cancels the session
        if (long_hit) begin
          outcome         = item.key_code;
          press_count_nxt = 16'd0;
          press_kind_nxt  = KEY_NONE;
        end else begin
          press_count_nxt = press_inc;
          press_kind_nxt  = item.key_code;
        end
      end else begin
        // Release of a short press edits the field or moves the selection
        if (short_ok) begin
          if (press_kind_r == KEY_A) begin
            case (field_select_r)
              SEL_SECONDS: edit_seconds_nxt =
                (edit_seconds_r < SEC_MIN_LAST) ? edit_seconds_r + 6'd1 : 6'd0;
              SEL_MINUTES: edit_minutes_nxt =
                (edit_minutes_r < SEC_MIN_LAST) ? edit_minutes_r + 6'd1 : 6'd0;
              SEL_HOURS:   edit_hours_nxt =
                (edit_hours_r < HOUR_LAST) ? edit_hours_r + 5'd1 : 5'd0;
              default: ;
            endcase
          end else if (press_kind_r == KEY_B) begin
            field_select_nxt = (field_select_r < SEL_HOURS) ? field_select_r + 2'd1
                                                            : SEL_SECONDS;
          end
        end
        press_count_nxt = 16'd0;
        press_kind_nxt  = KEY_NONE;
      end

      // Blink: the upper half of the period shows the digits, the lower half blanks
      if (outcome == OUT_EDITING) begin
        blink_count_nxt = blink_dec;
        if (blink_dec == 16'd0) begin
          blink_count_nxt = blink_period;
        end else if (blink_dec > half_period) begin
          latched_hours_nxt   = edit_hours_nxt;
          latched_minutes_nxt = edit_minutes_nxt;
          latched_seconds_nxt = edit_seconds_nxt;
          blanked_nxt         = 3'd0;
        end else if (blink_dec < half_period) begin
          case (field_select_nxt)
            SEL_SECONDS: blanked_nxt = blanked_r | 3'b001;
            SEL_MINUTES: blanked_nxt = blanked_r | 3'b010;
            SEL_HOURS:   blanked_nxt = blanked_r | 3'b100;
            default: ;
          endcase
        end
      end
    end
  end

  // Result word, with the BCD time only on a save
  assign bcd_h = to_bcd({1'b0, edit_hours_nxt});
  assign bcd_m = to_bcd(edit_minutes_nxt);
  assign bcd_s = to_bcd(edit_seconds_nxt);

  always_comb begin
    result.shown_hours    = latched_hours_nxt;
    result.shown_minutes  = latched_minutes_nxt;
    result.shown_seconds  = latched_seconds_nxt;
    result.blank_mask     = blanked_nxt;
    result.selected_field = field_select_nxt;
    result.outcome        = outcome;
    result.bcd_hours      = 6'd0;
    result.bcd_minutes    = 8'd0;
    result.bcd_seconds    = 8'd0;
    if (outcome == OUT_SAVED) begin
      result.bcd_hours   = bcd_h[5:0];
      result.bcd_minutes = bcd_m;
      result.bcd_seconds = bcd_s;
    end
  end

  // Session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edit_hours_r      <= 5'd0;
      edit_minutes_r    <= 6'd0;
      edit_seconds_r    <= 6'd0;
      field_select_r    <= SEL_SECONDS;
      press_count_r     <= 16'd0;
      press_kind_r      <= KEY_NONE;
      blink_count_r     <= BLINK_PERIOD_RESET;
      latched_hours_r   <= 5'd0;
      latched_minutes_r <= 6'd0;
      latched_seconds_r <= 6'd0;
      blanked_r         <= 3'd0;
    end else if (step_en) begin
      edit_hours_r      <= edit_hours_nxt;
      edit_minutes_r    <= edit_minutes_nxt;
      edit_seconds_r    <= edit_seconds_nxt;
      field_select_r    <= field_select_nxt;
      press_count_r     <= press_count_nxt;
      press_kind_r      <= press_kind_nxt;
      blink_count_r     <= blink_count_nxt;
      latched_hours_r   <= latched_hours_nxt;
      latched_minutes_r <= latched_minutes_nxt;
      latched_seconds_r <= latched_seconds_nxt;
      blanked_r         <= blanked_nxt;
    end
  end

endmodule
